// ===== rtl/mbavg_pkg.sv =====
// Shared types and constants for the multichannel boxcar average unit.
`default_nettype none

package mbavg_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int AVG_W     = 8;
  localparam int BIN_IDX_W = 5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic take;
    logic clr;
  } mbavg_req_t;

  typedef struct packed {
    logic slot_ok;
    logic last;
  } mbavg_pos_t;

endpackage

`default_nettype wire

// ===== rtl/mbavg_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`default_nettype none

interface mbavg_in_if;
  import mbavg_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface mbavg_out_if;
  import mbavg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [AVG_W-1:0]     average;
  logic                 frame_last;

  modport source (output valid, output bin_index, output average, output frame_last,
                  input ready);
  modport sink (input valid, input bin_index, input average, input frame_last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/multichannel_boxcar_average_unit.sv =====
// Top level of the multichannel boxcar average unit.
// Takes one input word per cycle while in_ch.ready is high, and loads each bin's
// average into the result register: accepting a word registers it and reads the
// bin's history byte and running total from their memories, and once the result
// register is empty or being read, the updated total is written back to both
// memories and the result register is loaded. The input stage empties into the
// result register, so a new word is taken while a result waits as long as the
// input stage is empty. A clear word gives no result and drops all history and
// totals at once through valid bits; there is no clearing pass after reset.
`default_nettype none

module multichannel_boxcar_average_unit #(
  parameter int BINS   = 24,
  parameter int FRAMES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mbavg_in_if.sink    in_ch,
  mbavg_out_if.source out_ch
);
  import mbavg_pkg::*;

  localparam int BIN_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SLOT_W = $clog2(FRAMES);

  mbavg_req_t        req;
  mbavg_pos_t        pos;
  logic [BIN_W-1:0]  bin;
  logic [SLOT_W-1:0] slot;
  logic              a_valid;
  logic              out_valid;
  logic              in_fire;

  assign in_ch.ready = !a_valid || !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign req.take    = in_fire && (in_ch.cmd == CMD_SAMPLE);
  assign req.clr     = in_fire && (in_ch.cmd == CMD_CLEAR);

  mbavg_seq #(
    .BINS   (BINS),
    .FRAMES (FRAMES),
    .BIN_W  (BIN_W),
    .SLOT_W (SLOT_W)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .bin   (bin),
    .slot  (slot),
    .pos   (pos)
  );

  mbavg_acc #(
    .BINS   (BINS),
    .FRAMES (FRAMES),
    .BIN_W  (BIN_W),
    .SLOT_W (SLOT_W)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .pos       (pos),
    .bin       (bin),
    .slot      (slot),
    .sample    (in_ch.sample),
    .out_ready (out_ch.ready),
    .a_valid   (a_valid),
    .out_valid (out_valid),
    .out_bin   (out_ch.bin_index),
    .out_avg   (out_ch.average),
    .out_last  (out_ch.frame_last)
  );

  assign out_ch.valid = out_valid;

  a_clear_empties_stage : assert property (@(posedge clk) disable iff (!rst_n)
    req.clr |=> !a_valid)
    else $error("stage holds a word after clear");

  a_sample_fills_stage : assert property (@(posedge clk) disable iff (!rst_n)
    req.take |=> a_valid)
    else $error("accepted sample word not held");

  a_stage_drains : assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid && (!out_valid || out_ch.ready)) |=> out_valid)
    else $error("result register not loaded");

  a_bin_wraps : assert property (@(posedge clk) disable iff (!rst_n)
    (req.take && pos.last) |=> (bin == '0))
    else $error("bin counter did not wrap after last bin");

endmodule

`default_nettype wire

// ===== rtl/mbavg_seq.sv =====
// Bin and frame slot counters with per-slot history valid bits.
`default_nettype none

module mbavg_seq #(
  parameter int BINS   = 24,
  parameter int FRAMES = 16,
  parameter int BIN_W  = 5,
  parameter int SLOT_W = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mbavg_pkg::mbavg_req_t req,
  output      logic [BIN_W-1:0]    bin,
  output      logic [SLOT_W-1:0]   slot,
  output      mbavg_pkg::mbavg_pos_t pos
);
  import mbavg_pkg::*;

  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FRAMES-1:0] slot_valid_r, slot_valid_nxt;
  logic              last;

  assign last = (bin_r == BIN_W'(BINS - 1));

  always_comb begin
    bin_nxt        = bin_r;
    slot_nxt       = slot_r;
    slot_valid_nxt = slot_valid_r;
    if (req.clr) begin
      bin_nxt        = '0;
      slot_nxt       = '0;
      slot_valid_nxt = '0;
    end else if (req.take) begin
      if (last) begin
        bin_nxt                = '0;
        slot_valid_nxt[slot_r] = 1'b1;
        slot_nxt = (slot_r == SLOT_W'(FRAMES - 1)) ? '0 : slot_r + SLOT_W'(1);
      end else begin
        bin_nxt = bin_r + BIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r        <= '0;
      slot_r       <= '0;
      slot_valid_r <= '0;
    end else begin
      bin_r        <= bin_nxt;
      slot_r       <= slot_nxt;
      slot_valid_r <= slot_valid_nxt;
    end
  end

  assign bin         = bin_r;
  assign slot        = slot_r;
  assign pos.slot_ok = slot_valid_r[slot_r];
  assign pos.last    = last;

endmodule

`default_nettype wire

// ===== rtl/mbavg_acc.sv =====
// History and total memories, running total update and result register.
`default_nettype none

module mbavg_acc #(
  parameter int BINS   = 24,
  parameter int FRAMES = 16,
  parameter int BIN_W  = 5,
  parameter int SLOT_W = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mbavg_pkg::mbavg_req_t         req,
  input  wire mbavg_pkg::mbavg_pos_t         pos,
  input  wire logic [BIN_W-1:0]              bin,
  input  wire logic [SLOT_W-1:0]             slot,
  input  wire logic [mbavg_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                          out_ready,
  output      logic                          a_valid,
  output      logic                          out_valid,
  output      logic [mbavg_pkg::BIN_IDX_W-1:0] out_bin,
  output      logic [mbavg_pkg::AVG_W-1:0]   out_avg,
  output      logic                          out_last
);
  import mbavg_pkg::*;

  localparam int TOT_W   = SAMPLE_W + SLOT_W;
  localparam int SHIFT   = TOT_W + SLOT_W;
  localparam int PROD_W  = 2 * TOT_W + 1;
  localparam int HIST_AW = SLOT_W + BIN_W;
  localparam int TOT_D   = BINS;
  localparam int HIST_D  = 2 ** HIST_AW;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(FRAMES) - 64'd1) / 64'(FRAMES);
  localparam logic [TOT_W:0] RECIP_C = (TOT_W + 1)'(RECIP);

  logic [SAMPLE_W-1:0] hist_mem [HIST_D];
  logic [TOT_W-1:0]    tot_mem [TOT_D];
  logic [TOT_D-1:0]    tot_valid_r, tot_valid_nxt;

  logic                a_valid_r, a_valid_nxt;
  logic [BIN_W-1:0]    a_bin_r;
  logic [SLOT_W-1:0]   a_slot_r;
  logic [SAMPLE_W-1:0] a_samp_r;
  logic                a_last_r;
  logic                a_sok_r;
  logic                a_tv_r;
  logic                a_fwd_r;
  logic [TOT_W-1:0]    a_ftot_r;
  logic [SAMPLE_W-1:0] hist_rd_r;
  logic [TOT_W-1:0]    tot_rd_r;

  logic                out_valid_r, out_valid_nxt;
  logic [BIN_IDX_W-1:0] out_bin_r;
  logic [AVG_W-1:0]    out_avg_r;
  logic                out_last_r;

  logic                b_load;
  logic [TOT_W-1:0]    base;
  logic [SAMPLE_W-1:0] old;
  logic [TOT_W:0]      sum;
  logic [TOT_W-1:0]    tot_new;
  logic [PROD_W-1:0]   prod;

  assign b_load = a_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    base = a_tv_r ? tot_rd_r : '0;
    if (a_fwd_r) begin
      base = a_ftot_r;
    end
    old = a_sok_r ? hist_rd_r : '0;
    sum = (TOT_W + 1)'(base) + (TOT_W + 1)'(a_samp_r);
    if (sum >= (TOT_W + 1)'(old)) begin
      tot_new = TOT_W'(sum - (TOT_W + 1)'(old));
    end else begin
      tot_new = '0;
    end
    prod = PROD_W'(tot_new) * PROD_W'(RECIP_C);
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (req.take) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    tot_valid_nxt = tot_valid_r;
    if (req.clr) begin
      tot_valid_nxt = '0;
    end else if (b_load) begin
      tot_valid_nxt[a_bin_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tot_valid_r <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tot_valid_r <= tot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.take) begin
      a_bin_r   <= bin;
      a_slot_r  <= slot;
      a_samp_r  <= sample;
      a_last_r  <= pos.last;
      a_sok_r   <= pos.slot_ok;
      a_tv_r    <= tot_valid_r[bin];
      a_fwd_r   <= b_load && (a_bin_r == bin);
      a_ftot_r  <= tot_new;
      hist_rd_r <= hist_mem[{slot, bin}];
      tot_rd_r  <= tot_mem[bin];
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      hist_mem[{a_slot_r, a_bin_r}] <= a_samp_r;
      tot_mem[a_bin_r]              <= tot_new;
      out_bin_r                     <= BIN_IDX_W'(a_bin_r);
      out_avg_r                     <= prod[SHIFT +: AVG_W];
      out_last_r                    <= a_last_r;
    end
  end

  assign a_valid   = a_valid_r;
  assign out_valid = out_valid_r;
  assign out_bin   = out_bin_r;
  assign out_avg   = out_avg_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the multichannel boxcar average unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbavg_pkg::*;

  localparam int          BINS     = 24;
  localparam int          FRAMES   = 16;
  localparam int unsigned N_RANDOM = 1128;
  localparam int unsigned LIMIT    = 500000;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin;
    logic [AVG_W-1:0]     avg;
    logic                 last;
  } avg_word_t;

  typedef enum {FILL_RANDOM, FILL_FULL, FILL_ZERO, FILL_EXTREMES} fill_t;

  class boxcar_scoreboard;
    logic [SAMPLE_W-1:0] hist [FRAMES][BINS];
    logic [FRAMES-1:0]   slot_ok;
    logic [11:0]         total [BINS];
    int unsigned         bin_ctr;
    int unsigned         slot;
    avg_word_t           due [$];
    int unsigned         errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (hist[f, b]) hist[f][b] = '0;
      foreach (total[b]) total[b] = '0;
      slot_ok = '0;
      bin_ctr = 0;
      slot    = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void note_word(logic cmd, logic [SAMPLE_W-1:0] s);
      logic [12:0] sum;
      logic [7:0]  old;
      avg_word_t   w;
      if (cmd == CMD_CLEAR) begin
        wipe();
        return;
      end
      old = slot_ok[slot] ? hist[slot][bin_ctr] : 8'd0;
      sum = 13'(total[bin_ctr]) + 13'(s);
      sum = (sum >= 13'(old)) ? sum - 13'(old) : 13'd0;
      total[bin_ctr]      = sum[11:0];
      hist[slot][bin_ctr] = s;
      w.bin  = BIN_IDX_W'(bin_ctr);
      w.avg  = AVG_W'(sum >> 4);
      w.last = (bin_ctr == BINS - 1);
      due.push_back(w);
      if (w.last) begin
        slot_ok[slot] = 1'b1;
        bin_ctr       = 0;
        slot          = (slot + 1) % FRAMES;
      end else begin
        bin_ctr = bin_ctr + 1;
      end
    endfunction

    task report(string msg);
      if (errors < 30) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [BIN_IDX_W-1:0] bin, logic [AVG_W-1:0] avg, logic last);
      avg_word_t w;
      if (due.size() == 0) begin
        report($sformatf("unexpected word bin=%0d avg=%0d last=%0b", bin, avg, last));
        return;
      end
      w = due.pop_front();
      if (bin !== w.bin)
        report($sformatf("bin_index got %0d want %0d", bin, w.bin));
      if (avg !== w.avg)
        report($sformatf("average of bin %0d got %0d want %0d", w.bin, avg, w.avg));
      if (last !== w.last)
        report($sformatf("frame_last of bin %0d got %0b want %0b", w.bin, last, w.last));
    endtask

    task close();
      if (due.size() != 0)
        report($sformatf("%0d words never arrived", due.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   in_take = 1'b0;
  int unsigned cycles = 0;

  boxcar_scoreboard sb = new();

  mbavg_in_if  in_ch();
  mbavg_out_if out_ch();

  multichannel_boxcar_average_unit #(
    .BINS   (BINS),
    .FRAMES (FRAMES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sample both channels mid-cycle; they stay stable until the next rising edge
  always @(negedge clk) begin
    in_take = rst_n && in_ch.valid && in_ch.ready;
    if (in_take) sb.note_word(in_ch.cmd, in_ch.sample);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.bin_index, out_ch.average, out_ch.frame_last);
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(fill_t fill);
    case (fill)
      FILL_FULL:     return 8'hFF;
      FILL_ZERO:     return 8'h00;
      FILL_EXTREMES: return $urandom_range(0, 1) ? 8'hFF - 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 1));
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [SAMPLE_W-1:0] s);
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_take);
  endtask

  task automatic hold_off(input int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned stall;
    bit          calm;
    stall = 0;
    calm  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycles % 256 == 0) calm = ($urandom_range(0, 4) == 0);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned block_left;
    fill_t       fill;
    bit          calm_tx;
    sent       = 0;
    fill       = FILL_FULL;
    block_left = 17 * BINS;
    calm_tx    = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_SAMPLE;
    in_ch.sample <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_CLEAR, 8'hA5);
    send_word(CMD_SAMPLE, 8'hFF);
    send_word(CMD_SAMPLE, 8'h00);
    send_word(CMD_SAMPLE, 8'h80);
    send_word(CMD_SAMPLE, 8'h7F);
    send_word(CMD_SAMPLE, 8'h55);
    send_word(CMD_SAMPLE, 8'hAA);
    send_word(CMD_SAMPLE, 8'h01);
    send_word(CMD_SAMPLE, 8'hFE);
    send_word(CMD_CLEAR, 8'h5A);
    send_word(CMD_CLEAR, 8'hFF);
    for (int i = 0; i < 11; i++) send_word(CMD_SAMPLE, i[0] ? 8'hFF : 8'h00);
    wait_drained();

    while (sent < N_RANDOM) begin
      if (sent % 64 == 0) calm_tx = ($urandom_range(0, 4) == 0);
      if (block_left == 0) begin
        fill       = fill_t'($urandom_range(0, 3));
        block_left = $urandom_range(2, 12) * BINS;
      end
      if (sent == N_RANDOM / 2 || $urandom_range(0, 249) == 0) wait_drained();
      if ($urandom_range(0, 299) == 0) begin
        send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        send_word(CMD_SAMPLE, pick_sample(fill));
        block_left--;
      end
      sent++;
      if (!calm_tx && $urandom_range(0, 2) == 0) hold_off(pick_gap());
    end

    wait_drained();
    repeat (8) @(posedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
